[sv/m68k_eau_pkg.sv]
package m68k_eau_pkg;

	localparam logic OP_WRITE_REG = 1'b0;
	localparam logic OP_COMPUTE_EA = 1'b1;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_WORD = 2'd1;

	localparam logic [3:0] MODE_DN = 4'd0;
	localparam logic [3:0] MODE_AN = 4'd1;
	localparam logic [3:0] MODE_AN_IND = 4'd2;
	localparam logic [3:0] MODE_AN_POSTINC = 4'd3;
	localparam logic [3:0] MODE_AN_PREDEC = 4'd4;
	localparam logic [3:0] MODE_AN_DISP = 4'd5;
	localparam logic [3:0] MODE_AN_INDEX = 4'd6;
	localparam logic [3:0] MODE_ABS_W = 4'd7;
	localparam logic [3:0] MODE_ABS_L = 4'd8;
	localparam logic [3:0] MODE_PC_DISP = 4'd9;
	localparam logic [3:0] MODE_PC_INDEX = 4'd10;
	localparam logic [3:0] MODE_IMM = 4'd11;

	localparam logic [2:0] STACK_REG = 3'd7;
	localparam int NUM_REGS = 8;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
		logic [1:0]  size_code;
		logic [3:0]  addr_mode;
		logic [2:0]  base_reg;
		logic [15:0] ext_first;
		logic [15:0] ext_second;
		logic [31:0] prog_counter;
	} item_t;

	typedef struct packed {
		logic [31:0] effective_address;
		logic [31:0] operand_value;
		logic        memory_access;
		logic        address_error;
		logic [1:0]  ext_words_used;
	} result_t;

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sext8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

[sv/m68k_effective_address_unit_top.sv]
// Register file (D0-D7, A0-A7) and effective-address unit. Each transfer on the item
// channel either writes one register (data registers merge at the operand size) or
// evaluates one of the twelve addressing modes, and yields exactly one result, in order.
// An item is registered on acceptance, evaluated in the next cycle against the register
// file and written to the result register, so throughput is one item per cycle while
// result_ready holds. An item passes from the input register to the result register,
// and waits in the input register while a held result is not taken. Register-file updates from
// an item (writes, predecrement, postincrement) are seen by the very next item. The
// item side keeps accepting while a result waits, until both the input and result
// registers are full.
module m68k_effective_address_unit_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  m68k_eau_pkg::item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output m68k_eau_pkg::result_t result
);

	m68k_eau_pkg::item_t   item_s1;
	logic                  valid_s1;
	m68k_eau_pkg::result_t result_q;
	logic                  result_valid_q;

	logic [31:0] dreg_q [m68k_eau_pkg::NUM_REGS];
	logic [31:0] areg_q [m68k_eau_pkg::NUM_REGS];

	logic        advance;
	logic        fire_s1;
	logic        in_fire;

	logic [31:0] size_mask;
	logic [31:0] step;
	logic [31:0] an_val;
	logic [31:0] dn_val;
	logic [31:0] idx_raw;
	logic [31:0] idx_term;
	logic [31:0] ea;
	logic [31:0] val;
	logic        mem;
	logic        err;
	logic [1:0]  ext;
	logic        is_byte;
	m68k_eau_pkg::result_t result_d;

	assign advance = !result_valid_q || result_ready;
	assign fire_s1 = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;
	assign in_fire = item_valid && item_ready;

	// operand size decode, size code three acts as long
	always_comb begin
		is_byte = (item_s1.size_code == m68k_eau_pkg::SIZE_BYTE);
		if (is_byte) begin
			size_mask = 32'h0000_00ff;
			step = (item_s1.base_reg == m68k_eau_pkg::STACK_REG) ? 32'd2 : 32'd1;
		end else if (item_s1.size_code == m68k_eau_pkg::SIZE_WORD) begin
			size_mask = 32'h0000_ffff;
			step = 32'd2;
		end else begin
			size_mask = 32'hffff_ffff;
			step = 32'd4;
		end
	end

	assign an_val = areg_q[item_s1.base_reg];
	assign dn_val = dreg_q[item_s1.base_reg];

	// brief extension word index
	always_comb begin
		idx_raw = item_s1.ext_first[15] ? areg_q[item_s1.ext_first[14:12]]
			: dreg_q[item_s1.ext_first[14:12]];
		if (!item_s1.ext_first[11]) begin
			idx_raw = m68k_eau_pkg::sext16(idx_raw[15:0]);
		end
		idx_term = idx_raw + m68k_eau_pkg::sext8(item_s1.ext_first[7:0]);
	end

	always_comb begin
		ea = '0;
		val = '0;
		mem = 1'b0;
		ext = 2'd0;
		if (item_s1.opcode == m68k_eau_pkg::OP_COMPUTE_EA) begin
			unique case (item_s1.addr_mode)
				m68k_eau_pkg::MODE_DN: begin
					ea = {29'd0, item_s1.base_reg};
					val = dn_val & size_mask;
				end
				m68k_eau_pkg::MODE_AN: begin
					ea = {29'd0, item_s1.base_reg};
					val = an_val & size_mask;
				end
				m68k_eau_pkg::MODE_AN_IND, m68k_eau_pkg::MODE_AN_POSTINC: begin
					ea = an_val;
					mem = 1'b1;
				end
				m68k_eau_pkg::MODE_AN_PREDEC: begin
					ea = an_val - step;
					mem = 1'b1;
				end
				m68k_eau_pkg::MODE_AN_DISP: begin
					ea = an_val + m68k_eau_pkg::sext16(item_s1.ext_first);
					mem = 1'b1;
					ext = 2'd1;
				end
				m68k_eau_pkg::MODE_AN_INDEX: begin
					ea = an_val + idx_term;
					mem = 1'b1;
					ext = 2'd1;
				end
				m68k_eau_pkg::MODE_ABS_W: begin
					ea = m68k_eau_pkg::sext16(item_s1.ext_first);
					mem = 1'b1;
					ext = 2'd1;
				end
				m68k_eau_pkg::MODE_ABS_L: begin
					ea = {item_s1.ext_first, item_s1.ext_second};
					mem = 1'b1;
					ext = 2'd2;
				end
				m68k_eau_pkg::MODE_PC_DISP: begin
					ea = item_s1.prog_counter + m68k_eau_pkg::sext16(item_s1.ext_first);
					mem = 1'b1;
					ext = 2'd1;
				end
				m68k_eau_pkg::MODE_PC_INDEX: begin
					ea = item_s1.prog_counter + idx_term;
					mem = 1'b1;
					ext = 2'd1;
				end
				m68k_eau_pkg::MODE_IMM: begin
					if (is_byte) begin
						ea = {24'd0, item_s1.ext_first[7:0]};
						ext = 2'd1;
					end else if (item_s1.size_code == m68k_eau_pkg::SIZE_WORD) begin
						ea = {16'd0, item_s1.ext_first};
						ext = 2'd1;
					end else begin
						ea = {item_s1.ext_first, item_s1.ext_second};
						ext = 2'd2;
					end
					val = ea;
				end
				default: begin
				end
			endcase
		end
		err = mem && !is_byte && ea[0];
		result_d.effective_address = ea;
		result_d.operand_value = val;
		result_d.memory_access = mem;
		result_d.address_error = err;
		result_d.ext_words_used = ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < m68k_eau_pkg::NUM_REGS; i++) begin
				dreg_q[i] <= '0;
				areg_q[i] <= '0;
			end
		end else if (fire_s1) begin
			if (item_s1.opcode == m68k_eau_pkg::OP_WRITE_REG) begin
				if (!item_s1.reg_index[3]) begin
					dreg_q[item_s1.reg_index[2:0]] <= (dreg_q[item_s1.reg_index[2:0]] & ~size_mask)
						| (item_s1.write_data & size_mask);
				end else begin
					areg_q[item_s1.reg_index[2:0]] <= item_s1.write_data;
				end
			end else if (item_s1.addr_mode == m68k_eau_pkg::MODE_AN_PREDEC) begin
				// written back even when the address faults
				areg_q[item_s1.base_reg] <= ea;
			end else if (item_s1.addr_mode == m68k_eau_pkg::MODE_AN_POSTINC && !err) begin
				areg_q[item_s1.base_reg] <= an_val + step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item;
		end
		if (fire_s1) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	a_err_needs_mem: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.address_error |-> result.memory_access)
		else $error("address error on a non-memory operand");

	a_err_odd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.address_error |-> result.effective_address[0])
		else $error("address error on an even address");

	a_ext_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.ext_words_used != 2'd3)
		else $error("extension word count out of range");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> result_valid)
		else $error("evaluated item lost before the result register");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input stage empty but not ready");

endmodule
